// ===== rtl/utfd_pkg.sv =====
// shared types and constants for the utf-8 code point decoder
package utfd_pkg;

  localparam int CP_W  = 21;
  localparam int CNT_W = 3;

  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

  // lead byte classes
  typedef enum logic [2:0] {
    LEAD_ASCII = 3'd0,
    LEAD_SEQ2  = 3'd2,
    LEAD_SEQ3  = 3'd3,
    LEAD_SEQ4  = 3'd4,
    LEAD_BAD   = 3'd7
  } lead_t;

  // decoder state carried between bytes
  typedef struct packed {
    logic [CP_W-1:0] partial_code;
    logic [2:0]      seq_len;
    logic [1:0]      cont_seen;
  } dec_state_t;

  // per-byte outcome: cnt results, all replacements except possibly the last
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [CP_W-1:0]  last_cp;
    logic             last_rep;
  } dec_res_t;

  function automatic lead_t classify_lead(input logic [7:0] b);
    lead_t l;
    if (!b[7])                 l = LEAD_ASCII;
    else if (b[7:5] == 3'b110)   l = LEAD_SEQ2;
    else if (b[7:4] == 4'b1110)  l = LEAD_SEQ3;
    else if (b[7:3] == 5'b11110) l = LEAD_SEQ4;
    else                       l = LEAD_BAD;
    return l;
  endfunction

endpackage

// ===== rtl/utfd_in_if.sv =====
// input channel: one text byte per beat
interface utfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== rtl/utfd_out_if.sv =====
// result channel: one code point per beat
interface utfd_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        is_replacement;
  logic        run_last;

  modport source (output valid, output code_point, output is_replacement,
                  output run_last, input ready);
  modport sink   (input valid, input code_point, input is_replacement,
                  input run_last, output ready);
endinterface

// ===== rtl/utf8_code_point_decoder_unit.sv =====
// top level of the utf-8 code point decoder
//
// usage: bytes of utf-8 text enter on in_bus, one byte per beat, with
// end_of_text set on the last byte of a text. decoded code points leave on
// out_bus, one per beat; run_last marks the final result of each byte.
// a byte that completes nothing (a lead or a middle continuation) yields
// no result. a byte can yield up to four results: replacements for a broken
// or unterminated sequence, then its own result.
// flow: a byte is registered on acceptance and decoded against the
// sequence state once the output register is empty or on its last beat;
// its first result is then loaded into the output register and held there.
// throughput: one byte per cycle while out_bus.ready is high and each
// byte yields at most one result; a byte with more results holds the output
// register until its last is taken, and the input register takes one more byte.
// reset (rst_n low, synchronous) empties both registers and closes any
// open sequence. when out_bus.ready is low the current result holds and
// in_bus.ready drops once the input register is full.
module utf8_code_point_decoder_unit
  import utfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  utfd_in_if.sink    in_bus,
  utfd_out_if.source out_bus
);

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_eot_r;

  dec_state_t st_r;
  dec_state_t st_nxt;
  dec_res_t   res;

  logic [CNT_W-1:0] job_cnt_r;
  logic [CP_W-1:0]  job_cp_r;
  logic             job_rep_r;

  logic mv;
  logic out_fire;

  utfd_core u_core (
    .st          (st_r),
    .text_byte   (in_byte_r),
    .end_of_text (in_eot_r),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  assign out_fire = out_bus.valid && out_bus.ready;
  // decode the held byte once the output register is empty or on its last beat
  assign mv = in_v_r && ((job_cnt_r == '0) || ((job_cnt_r == CNT_W'(1)) && out_bus.ready));
  assign in_bus.ready = !in_v_r || mv;

  assign out_bus.valid          = (job_cnt_r != '0);
  assign out_bus.run_last       = (job_cnt_r == CNT_W'(1));
  assign out_bus.code_point     = out_bus.run_last ? job_cp_r : REPL_CP;
  assign out_bus.is_replacement = out_bus.run_last ? job_rep_r : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_bus.valid && in_bus.ready) begin
      in_v_r <= 1'b1;
    end else if (mv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_byte_r <= in_bus.text_byte;
      in_eot_r  <= in_bus.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '0;
      job_cnt_r <= '0;
    end else if (mv) begin
      st_r      <= st_nxt;
      job_cnt_r <= res.cnt;
    end else if (out_fire) begin
      job_cnt_r <= job_cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mv) begin
      job_cp_r  <= res.last_cp;
      job_rep_r <= res.last_rep;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    job_cnt_r <= CNT_W'(4))
    else $error("result count out of range");

  a_no_move_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (job_cnt_r > CNT_W'(1)) |-> !mv)
    else $error("byte decoded while a result burst is pending");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && !out_bus.ready) |=> $stable(job_cnt_r))
    else $error("result count moved during stall");

  a_seq_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.seq_len == 3'd0) || (st_r.seq_len == 3'd2) || (st_r.seq_len == 3'd3)
    || (st_r.seq_len == 3'd4))
    else $error("illegal sequence length");

  a_cont_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.seq_len != 3'd0) |-> (({1'b0, st_r.cont_seen} + 3'd1) < st_r.seq_len))
    else $error("open sequence already complete");

endmodule

// ===== rtl/utfd_core.sv =====
// combinational step: one byte against the decoder state
module utfd_core
  import utfd_pkg::*;
(
  input  dec_state_t st,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output dec_state_t st_nxt,
  output dec_res_t   res
);

  lead_t      lead;
  logic       is_open;
  logic       is_cont;
  logic [1:0] cs_inc;
  logic [2:0] pre;
  logic [CP_W-1:0] pc_shift;
  logic [CP_W-1:0] lead_bits;

  always_comb begin
    lead     = classify_lead(text_byte);
    is_open  = (st.seq_len != 3'd0);
    is_cont  = (text_byte[7:6] == 2'b10);
    cs_inc   = st.cont_seen + 2'd1;
    pc_shift = {st.partial_code[CP_W-7:0], text_byte[5:0]};
    pre      = is_open ? ({1'b0, st.cont_seen} + 3'd1) : 3'd0;

    case (lead)
      LEAD_SEQ2: lead_bits = {16'd0, text_byte[4:0]};
      LEAD_SEQ3: lead_bits = {17'd0, text_byte[3:0]};
      LEAD_SEQ4: lead_bits = {18'd0, text_byte[2:0]};
      default:   lead_bits = '0;
    endcase

    st_nxt       = '0;
    res.cnt      = '0;
    res.last_cp  = REPL_CP;
    res.last_rep = 1'b1;

    if (is_open && is_cont) begin
      if (({1'b0, cs_inc} + 3'd1) >= st.seq_len) begin
        res.cnt      = 3'd1;
        res.last_cp  = pc_shift;
        res.last_rep = 1'b0;
      end else if (end_of_text) begin
        // open at end of text: lead plus accepted continuations
        res.cnt = {1'b0, cs_inc} + 3'd1;
      end else begin
        st_nxt.partial_code = pc_shift;
        st_nxt.seq_len      = st.seq_len;
        st_nxt.cont_seen    = cs_inc;
      end
    end else begin
      // broken sequence flushes first, then the byte is taken as a lead
      case (lead)
        LEAD_ASCII: begin
          res.cnt      = pre + 3'd1;
          res.last_cp  = {13'd0, text_byte};
          res.last_rep = 1'b0;
        end
        LEAD_SEQ2, LEAD_SEQ3, LEAD_SEQ4: begin
          if (end_of_text) begin
            res.cnt = pre + 3'd1;
          end else begin
            res.cnt             = pre;
            st_nxt.partial_code = lead_bits;
            st_nxt.seq_len      = lead;
            st_nxt.cont_seen    = 2'd0;
          end
        end
        default: begin
          res.cnt = pre + 3'd1;
        end
      endcase
    end
  end

endmodule
